// ===== design/oaid_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// oaid_pkg: shared types and constants of the ordered array block
// Opcode and status codes, field widths and the command struct that the
// control logic broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package oaid_pkg;

   localparam int CAPACITY_DEFAULT = 128;
   localparam int DATA_WIDTH       = 32;
   localparam int POS_WIDTH        = 8;
   localparam int COUNT_WIDTH      = 8;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_DELETE = 1'b1
   } oaid_opcode_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_BADPOS = 2'd1,
      ST_FULL   = 2'd2
   } oaid_status_type;

   // command seen by every cell in the cycle an item is accepted
   typedef struct packed {
      logic                  shift_up;
      logic                  shift_down;
      logic [POS_WIDTH-1:0]  slot;
      logic [DATA_WIDTH-1:0] value;
   } oaid_cmd_type;

endpackage : oaid_pkg
`default_nettype wire

// ===== design/oaid_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// oaid_if: request and response channels of the ordered array block
// Valid/ready channels; an item moves at a clock edge with both high.
// ----------------------------------------------------------------------------
interface oaid_req_if;
   import oaid_pkg::*;

   logic                         valid;
   logic                         ready;
   logic                         opcode;
   logic [POS_WIDTH-1:0]         position;
   logic signed [DATA_WIDTH-1:0] value;

   modport source (output valid, output opcode, output position, output value,
                   input ready);
   modport sink   (input valid, input opcode, input position, input value,
                   output ready);
endinterface : oaid_req_if

interface oaid_rsp_if;
   import oaid_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [1:0]                   status;
   logic signed [DATA_WIDTH-1:0] removed_value;
   logic [COUNT_WIDTH-1:0]       count_after;

   modport source (output valid, output status, output removed_value,
                   output count_after, input ready);
   modport sink   (input valid, input status, input removed_value,
                   input count_after, output ready);
endinterface : oaid_rsp_if
`default_nettype wire

// ===== design/ordered_array_insert_delete.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_array_insert_delete: positional insert and delete on an ordered list
// Usage:
//   req_if carries one operation per item: opcode (insert or delete), a
//   1-based position and, for an insert, the value. rsp_if returns exactly one
//   item per request: status (ok, bad position, full), the removed value of
//   a successful delete (else zero) and the entry count after the operation.
//   Storage is a row of CAPACITY cells; the cells at and above the slot update
//   together in the same cycle, so an operation finishes in the cycle it is
//   accepted. The response is registered and is valid in the cycle after the accept.
//   Throughput: one item per cycle while the receiver takes each response;
//   the response register and the cell row update together, so a new item
//   is taken whenever the response register is empty or being drained.
//   When the receiver stalls, the response holds and req_if.ready drops
//   until it is taken.
//   Reset clears the entry count and the response valid and holds
//   req_if.ready low; entry contents are not cleared, since only live
//   entries are ever read.
// ----------------------------------------------------------------------------
module ordered_array_insert_delete #(
   parameter int CAPACITY = oaid_pkg::CAPACITY_DEFAULT
) (
   input  wire        clock,
   input  wire        reset,
   oaid_req_if.sink   req_if,
   oaid_rsp_if.source rsp_if
);
   import oaid_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] CAP_COUNT = COUNT_WIDTH'(CAPACITY);

   logic [COUNT_WIDTH-1:0] entry_count_ff;
   logic [COUNT_WIDTH-1:0] entry_count_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [1:0]             status_ff;
   logic [1:0]             status_in;
   logic [DATA_WIDTH-1:0]  removed_ff;
   logic [DATA_WIDTH-1:0]  removed_in;
   logic [COUNT_WIDTH-1:0] count_after_ff;

   logic                   accept;
   logic                   pos_zero;
   logic                   ins_past_end;
   logic                   del_past_end;
   logic                   full;
   logic [DATA_WIDTH-1:0]  read_value;
   oaid_cmd_type           cmd;

   logic [DATA_WIDTH-1:0]  entry [CAPACITY];
   logic [DATA_WIDTH-1:0]  tap   [CAPACITY];

   assign req_if.ready = !reset && (!rsp_valid_ff || rsp_if.ready);
   assign accept       = req_if.valid && req_if.ready;

   // check the position against the live count
   assign pos_zero     = (req_if.position == '0);
   assign ins_past_end = ({1'b0, req_if.position} > ({1'b0, entry_count_ff} + 9'd1));
   assign del_past_end = (req_if.position > entry_count_ff);
   assign full         = (entry_count_ff >= CAP_COUNT);

   // decode the operation into a command and a status
   always_comb begin
      cmd.shift_up   = 1'b0;
      cmd.shift_down = 1'b0;
      cmd.slot       = req_if.position - POS_WIDTH'(1);
      cmd.value      = req_if.value;
      status_in      = ST_OK;
      removed_in     = '0;
      entry_count_in = entry_count_ff;
      unique case (oaid_opcode_type'(req_if.opcode))
         OP_INSERT: begin
            if (pos_zero || ins_past_end) begin
               status_in = ST_BADPOS;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               cmd.shift_up   = accept;
               entry_count_in = entry_count_ff + COUNT_WIDTH'(1);
            end
         end
         OP_DELETE: begin
            if (pos_zero || del_past_end) begin
               status_in = ST_BADPOS;
            end else begin
               cmd.shift_down = accept;
               removed_in     = read_value;
               entry_count_in = entry_count_ff - COUNT_WIDTH'(1);
            end
         end
         default: begin
            status_in = ST_BADPOS;
         end
      endcase
   end

   // build the row of cells, each wired to its neighbors
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_data;
      logic [DATA_WIDTH-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_left
         assign left_data = entry[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_right
         assign right_data = entry[i+1];
      end

      oaid_cell #(
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (entry[i]),
         .tap        (tap[i])
      );
   end

   // merge the cell taps into the read value of the addressed entry
   always_comb begin
      read_value = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         read_value = read_value | tap[k];
      end
   end

   // advance the response valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // hold count and response valid under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            entry_count_ff <= entry_count_in;
         end
      end
   end

   // load the response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff      <= status_in;
         removed_ff     <= removed_in;
         count_after_ff <= entry_count_in;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.status        = status_ff;
   assign rsp_if.removed_value = removed_ff;
   assign rsp_if.count_after   = count_after_ff;

endmodule : ordered_array_insert_delete
`default_nettype wire

// ===== design/oaid_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// oaid_cell: one storage place of the ordered array
// Holds one entry; on a command it keeps it, takes the left neighbor's entry
// (insert below it), the new value (insert here) or the right neighbor's
// entry (delete at or below it). Drives its entry on the tap when selected.
// ----------------------------------------------------------------------------
module oaid_cell #(
   parameter int INDEX = 0
) (
   input  wire                                 clock,
   input  wire oaid_pkg::oaid_cmd_type         cmd,
   input  wire logic [oaid_pkg::DATA_WIDTH-1:0] left_data,
   input  wire logic [oaid_pkg::DATA_WIDTH-1:0] right_data,
   output logic [oaid_pkg::DATA_WIDTH-1:0]      data,
   output logic [oaid_pkg::DATA_WIDTH-1:0]      tap
);
   import oaid_pkg::*;

   localparam logic [POS_WIDTH-1:0] MY_SLOT = POS_WIDTH'(INDEX);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;
   logic                  above;
   logic                  here;

   assign above = (MY_SLOT > cmd.slot);
   assign here  = (MY_SLOT == cmd.slot);

   // pick the next entry from the neighbors or the new value
   always_comb begin
      data_in = data_ff;
      if (cmd.shift_up) begin
         if (above) begin
            data_in = left_data;
         end else if (here) begin
            data_in = cmd.value;
         end
      end else if (cmd.shift_down) begin
         if (above || here) begin
            data_in = right_data;
         end
      end
   end

   // hold the entry
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
   assign tap  = here ? data_ff : '0;

endmodule : oaid_cell
`default_nettype wire

// ===== tb/sv/oaid_list_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaid_list_checker: result checker for the ordered array block
// Watches both channels. Each accepted request is applied to a local copy
// of the list, and the expected response is queued. Each accepted response
// is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module oaid_list_checker #(
   parameter int CAPACITY = oaid_pkg::CAPACITY_DEFAULT
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   input  wire                                   req_ready,
   input  wire                                   req_opcode,
   input  wire [oaid_pkg::POS_WIDTH-1:0]         req_position,
   input  wire signed [oaid_pkg::DATA_WIDTH-1:0] req_value,
   input  wire                                   rsp_valid,
   input  wire                                   rsp_ready,
   input  wire [1:0]                             rsp_status,
   input  wire signed [oaid_pkg::DATA_WIDTH-1:0] rsp_removed_value,
   input  wire [oaid_pkg::COUNT_WIDTH-1:0]       rsp_count_after,
   output int                                    mismatch_count,
   output int                                    pending_count
);
   import oaid_pkg::*;

   typedef struct {
      oaid_status_type              status;
      logic signed [DATA_WIDTH-1:0] removed;
      logic [COUNT_WIDTH-1:0]       count;
   } list_outcome_type;

   logic signed [DATA_WIDTH-1:0] list_store [0:CAPACITY-1];
   int                           live_count = 0;
   list_outcome_type             pending_outcomes [$];
   int                           error_total = 0;

   // print one line and count it
   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      error_total++;
   endtask

   // apply one operation to the local list and return its response
   function automatic list_outcome_type apply_list_op(input logic op,
                                                      input logic [POS_WIDTH-1:0] pos,
                                                      input logic signed [DATA_WIDTH-1:0] val);
      list_outcome_type outcome;
      int               slot;
      int               i;
      outcome.status  = ST_OK;
      outcome.removed = '0;
      if (op == OP_INSERT) begin
         if (pos == 0 || int'(pos) > live_count + 1) begin
            outcome.status = ST_BADPOS;
         end else if (live_count >= CAPACITY) begin
            outcome.status = ST_FULL;
         end else begin
            slot = int'(pos) - 1;
            for (i = live_count; i > slot; i--) begin
               list_store[i] = list_store[i-1];
            end
            list_store[slot] = val;
            live_count++;
         end
      end else begin
         if (pos == 0 || int'(pos) > live_count) begin
            outcome.status = ST_BADPOS;
         end else begin
            slot = int'(pos) - 1;
            outcome.removed = list_store[slot];
            for (i = slot; i + 1 < live_count; i++) begin
               list_store[i] = list_store[i+1];
            end
            live_count--;
         end
      end
      outcome.count = live_count[COUNT_WIDTH-1:0];
      return outcome;
   endfunction

   // check responses before queuing new requests: a response never
   // belongs to the request taken at the same edge
   always @(posedge clock) begin
      list_outcome_type oldest;
      if (reset) begin
         live_count = 0;
         pending_outcomes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_outcomes.size() == 0) begin
               report_mismatch("response item with no request waiting");
            end else begin
               oldest = pending_outcomes.pop_front();
               if (rsp_status !== oldest.status)
                  report_mismatch($sformatf("status expected %0d got %0d",
                                            oldest.status, rsp_status));
               if (rsp_removed_value !== oldest.removed)
                  report_mismatch($sformatf("removed_value expected %0h got %0h",
                                            oldest.removed, rsp_removed_value));
               if (rsp_count_after !== oldest.count)
                  report_mismatch($sformatf("count_after expected %0d got %0d",
                                            oldest.count, rsp_count_after));
            end
         end
         if (req_valid && req_ready)
            pending_outcomes.push_back(apply_list_op(req_opcode, req_position,
                                                     req_value));
      end
      mismatch_count <= error_total;
      pending_count  <= pending_outcomes.size();
   end

endmodule : oaid_list_checker

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for ordered_array_insert_delete
// Drives directed inserts and deletes over the edge cases, then long
// random grow and shrink sweeps that fill and empty the list several
// times, with random idle bursts on both channels. A checker module
// predicts and compares every response.
// ----------------------------------------------------------------------------
module testbench;
   import oaid_pkg::*;

   localparam int LIST_CAPACITY = CAPACITY_DEFAULT;
   localparam int RANDOM_ITEMS  = 1800;
   localparam int QUIET_ITEMS   = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   idle_on = 1'b1;
   int   failures;
   int   outstanding;
   int   shadow_len = 0;
   bit   growing = 1'b1;

   oaid_req_if req_bus();
   oaid_rsp_if rsp_bus();

   ordered_array_insert_delete #(.CAPACITY(LIST_CAPACITY)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   oaid_list_checker #(.CAPACITY(LIST_CAPACITY)) list_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_bus.valid),
      .req_ready         (req_bus.ready),
      .req_opcode        (req_bus.opcode),
      .req_position      (req_bus.position),
      .req_value         (req_bus.value),
      .rsp_valid         (rsp_bus.valid),
      .rsp_ready         (rsp_bus.ready),
      .rsp_status        (rsp_bus.status),
      .rsp_removed_value (rsp_bus.removed_value),
      .rsp_count_after   (rsp_bus.count_after),
      .mismatch_count    (failures),
      .pending_count     (outstanding)
   );

   always #6 clock = ~clock;

   // stall the response side in random bursts
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
      end
   end

   // send one item, starting and ending at a falling edge
   task automatic push_request(input oaid_opcode_type op, input logic [7:0] pos,
                               input logic signed [31:0] val);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.opcode   <= op;
      req_bus.position <= pos;
      req_bus.value    <= val;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      // track the length to aim positions at the live range
      if (op == OP_INSERT) begin
         if (pos != 0 && int'(pos) <= shadow_len + 1 && shadow_len < LIST_CAPACITY)
            shadow_len++;
      end else if (pos != 0 && int'(pos) <= shadow_len) begin
         shadow_len--;
      end
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'hFFFF_FFFF;
         3:       return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   // one random item: mostly legal positions, some noise
   task automatic random_request();
      oaid_opcode_type op;
      logic [7:0]      pos;
      int              limit;
      int              roll;
      roll = $urandom_range(0, 99);
      if (roll < 80)
         op = growing ? OP_INSERT : OP_DELETE;
      else
         op = growing ? OP_DELETE : OP_INSERT;
      limit = (op == OP_INSERT) ? shadow_len + 1 : shadow_len;
      roll = $urandom_range(0, 99);
      if (roll < 8)
         pos = 8'($urandom_range(0, 255));
      else if (roll < 11)
         pos = 8'd0;
      else if (roll < 13)
         pos = 8'd255;
      else if (roll < 16)
         pos = 8'(limit + 1);
      else if (limit == 0)
         pos = 8'($urandom_range(0, 2));
      else if (roll < 24)
         pos = 8'd1;
      else if (roll < 32)
         pos = 8'(limit);
      else
         pos = 8'($urandom_range(1, limit));
      push_request(op, pos, pick_value());
      // turn around at the ends after a few hits on full or empty
      if (growing && shadow_len == LIST_CAPACITY && $urandom_range(0, 3) == 0)
         growing = 1'b0;
      else if (!growing && shadow_len == 0 && $urandom_range(0, 3) == 0)
         growing = 1'b1;
   endtask

   // stimulus
   initial begin
      req_bus.valid    = 1'b0;
      req_bus.opcode   = OP_INSERT;
      req_bus.position = '0;
      req_bus.value    = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty list: every delete and any out-of-range insert is refused
      push_request(OP_DELETE, 8'd1,   32'h0000_0000);
      push_request(OP_DELETE, 8'd0,   32'h0000_0000);
      push_request(OP_DELETE, 8'd255, 32'hFFFF_FFFF);
      push_request(OP_INSERT, 8'd0,   32'h0000_0005);
      push_request(OP_INSERT, 8'd2,   32'h0000_0006);
      push_request(OP_INSERT, 8'd255, 32'h0000_0007);
      // build front, end and middle inserts with extreme values
      push_request(OP_INSERT, 8'd1,   32'h8000_0000);
      push_request(OP_INSERT, 8'd1,   32'h7FFF_FFFF);
      push_request(OP_INSERT, 8'd3,   32'h0000_0000);
      push_request(OP_INSERT, 8'd2,   32'hFFFF_FFFF);
      // positions just past the end
      push_request(OP_INSERT, 8'd6,   32'h1234_5678);
      push_request(OP_DELETE, 8'd5,   32'h0000_0000);
      push_request(OP_DELETE, 8'd0,   32'h0000_0000);
      // delete at end and front
      push_request(OP_DELETE, 8'd4,   32'h0000_0000);
      push_request(OP_DELETE, 8'd1,   32'hFFFF_FFFF);
      push_request(OP_INSERT, 8'd2,   32'h5555_5555);
      push_request(OP_INSERT, 8'd1,   32'hAAAA_AAAA);
      push_request(OP_DELETE, 8'd2,   32'h0000_0000);
      push_request(OP_DELETE, 8'd255, 32'h0000_0000);
      // drain back to empty
      push_request(OP_DELETE, 8'd1,   32'h0000_0000);
      push_request(OP_DELETE, 8'd1,   32'h0000_0000);
      push_request(OP_DELETE, 8'd1,   32'h0000_0000);
      push_request(OP_DELETE, 8'd1,   32'h0000_0000);

      // random grow and shrink sweeps; no idling near the end
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - QUIET_ITEMS)
            idle_on = 1'b0;
         random_request();
      end
      req_bus.valid <= 1'b0;

      // wait for the last responses, then let the pipe settle
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // hard stop
   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule : testbench
